// ===== rtl/core/crb_pkg.sv =====
package crb_pkg;

  localparam int unsigned NodeW = 16;
  localparam int unsigned ColW = 17;
  localparam int unsigned StartW = 22;

  // Rows wrap after the last node, or after node 65535 if that comes first.
  localparam int unsigned MaxNodes = 65536;
  localparam int unsigned RowWrap = ((MaxNodes < 65536) ? MaxNodes : 65536) - 1;

  localparam int unsigned RowCapacity = 32;
  localparam int unsigned CmdDepth = 4;

  localparam logic OP_NEIGHBOUR = 1'b0;
  localparam logic OP_END = 1'b1;

  typedef struct packed {
    logic            is_end;
    logic [ColW-1:0] column;
  } cmd_t;

  typedef enum logic [1:0] {
    S_BUILD = 2'b01,
    S_DRAIN = 2'b10
  } back_state_e;

endpackage

// ===== rtl/core/crb_front.sv =====
module crb_front import crb_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic             op_i,
  input  logic [NodeW-1:0] neighbour_node_i,
  output logic             full_o,
  output logic             cmd_valid_o,
  output cmd_t             cmd_o,
  input  logic             cmd_ready_i
);

  localparam int unsigned PtrW = (CmdDepth > 1) ? $clog2(CmdDepth) : 1;
  localparam int unsigned CntW = $clog2(CmdDepth + 1);

  cmd_t            cmd_q [CmdDepth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  cmd_t            new_cmd;
  logic            push_ok;
  logic            pop_ok;

  // Each transaction is classified here and converted to a one-based column.
  always_comb begin
    new_cmd.is_end = (op_i == OP_END);
    new_cmd.column = ColW'(neighbour_node_i) + ColW'(1);
  end

  assign full_o      = (count_q == CntW'(CmdDepth));
  assign cmd_valid_o = (count_q != '0);
  assign cmd_o       = cmd_q[rd_ptr_q];
  assign push_ok     = push_i && !full_o;
  assign pop_ok      = cmd_valid_o && cmd_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_ok) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(CmdDepth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop_ok) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(CmdDepth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (push_ok && !pop_ok) begin
      count_d = count_q + CntW'(1);
    end else if (!push_ok && pop_ok) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_ok) begin
      cmd_q[wr_ptr_q] <= new_cmd;
    end
  end

endmodule

// ===== rtl/core/crb_back.sv =====
module crb_back import crb_pkg::*; #(
  parameter int unsigned ROW_CAPACITY = RowCapacity
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cmd_valid_i,
  input  cmd_t              cmd_i,
  output logic              cmd_ready_o,
  output logic              empty_o,
  input  logic              pop_i,
  output logic [ColW-1:0]   column_o,
  output logic [StartW-1:0] row_start_o,
  output logic [NodeW-1:0]  row_number_o,
  output logic              last_in_row_o,
  output logic              row_overflow_o
);

  localparam int unsigned FillW = $clog2(ROW_CAPACITY + 1);

  back_state_e       state_q, state_d;
  logic [FillW-1:0]  fill_q, fill_d;
  logic [NodeW-1:0]  row_q, row_d;
  logic [StartW-1:0] total_q, total_d;
  logic              ovf_q, ovf_d;
  logic              out_valid_q, out_valid_d;

  logic [ColW-1:0]   cells_q [ROW_CAPACITY];
  logic [ColW-1:0]   ins_cells [ROW_CAPACITY];
  logic [ROW_CAPACITY-1:0] gt;

  logic [NodeW-1:0]  drain_row_q;
  logic [StartW-1:0] drain_start_q;
  logic              drain_ovf_q;

  logic [ColW-1:0]   out_column_q;
  logic [StartW-1:0] out_start_q;
  logic [NodeW-1:0]  out_row_q;
  logic              out_last_q;
  logic              out_ovf_q;

  logic              take;
  logic              take_end;
  logic              insert_en;
  logic              load_out;
  logic              drain_last;
  logic [ColW-1:0]   key;

  assign cmd_ready_o = (state_q == S_BUILD);
  assign take        = cmd_valid_i && cmd_ready_o;
  assign take_end    = take && cmd_i.is_end;
  assign key         = cmd_i.is_end ? (ColW'(row_q) + ColW'(1)) : cmd_i.column;
  // A neighbour only fits while a slot stays free for the diagonal.
  assign insert_en   = take && (cmd_i.is_end || (fill_q < FillW'(ROW_CAPACITY - 1)));
  assign load_out    = (state_q == S_DRAIN) && (!out_valid_q || pop_i);
  assign drain_last  = (fill_q == FillW'(1));

  // The row is kept sorted; every cell decides in parallel whether it keeps
  // its value, takes the new key or takes its left neighbor.
  always_comb begin
    for (int i = 0; i < ROW_CAPACITY; i++) begin
      gt[i] = (FillW'(i) < fill_q) && (cells_q[i] > key);
    end
    for (int i = 0; i < ROW_CAPACITY; i++) begin
      if (i > 0 && gt[(i > 0) ? i - 1 : 0]) begin
        ins_cells[i] = cells_q[(i > 0) ? i - 1 : 0];
      end else if (gt[i] || FillW'(i) == fill_q) begin
        ins_cells[i] = key;
      end else begin
        ins_cells[i] = cells_q[i];
      end
    end
  end

  always_comb begin
    state_d     = state_q;
    fill_d      = fill_q;
    row_d       = row_q;
    total_d     = total_q;
    ovf_d       = ovf_q;
    out_valid_d = out_valid_q;
    if (pop_i) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      S_BUILD: begin
        if (take_end) begin
          fill_d  = fill_q + FillW'(1);
          total_d = total_q + StartW'(fill_q) + StartW'(1);
          row_d   = (row_q == NodeW'(RowWrap)) ? '0 : row_q + NodeW'(1);
          ovf_d   = 1'b0;
          state_d = S_DRAIN;
        end else if (take) begin
          if (insert_en) begin
            fill_d = fill_q + FillW'(1);
          end else begin
            ovf_d = 1'b1;
          end
        end
      end
      S_DRAIN: begin
        if (load_out) begin
          out_valid_d = 1'b1;
          fill_d      = fill_q - FillW'(1);
          if (drain_last) begin
            state_d = S_BUILD;
          end
        end
      end
      default: begin
        state_d = S_BUILD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_BUILD;
      fill_q      <= '0;
      row_q       <= '0;
      total_q     <= '0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      fill_q      <= fill_d;
      row_q       <= row_d;
      total_q     <= total_d;
      ovf_q       <= ovf_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (insert_en) begin
      for (int i = 0; i < ROW_CAPACITY; i++) begin
        cells_q[i] <= ins_cells[i];
      end
    end else if (load_out) begin
      // The smallest column sits at the head; the row moves up by one.
      for (int i = 0; i < ROW_CAPACITY - 1; i++) begin
        cells_q[i] <= cells_q[i + 1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_end) begin
      drain_row_q   <= row_q;
      drain_start_q <= total_q;
      drain_ovf_q   <= ovf_q;
    end
    if (load_out) begin
      out_column_q <= cells_q[0];
      out_start_q  <= drain_start_q;
      out_row_q    <= drain_row_q;
      out_last_q   <= drain_last;
      out_ovf_q    <= drain_ovf_q;
    end
  end

  assign empty_o        = !out_valid_q;
  assign column_o       = out_column_q;
  assign row_start_o    = out_start_q;
  assign row_number_o   = out_row_q;
  assign last_in_row_o  = out_last_q;
  assign row_overflow_o = out_ovf_q;

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FillW'(ROW_CAPACITY))
    else $error("row fill exceeds capacity");

  a_drain_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DRAIN) |-> (fill_q != '0))
    else $error("draining an empty row");

  a_last_returns: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load_out && drain_last) |=> (state_q == S_BUILD && fill_q == '0))
    else $error("row not closed after its last column");

  a_column_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_column_q != '0))
    else $error("zero column on the result ports");

endmodule

// ===== rtl/core/csr_row_builder_with_diagonal_sort.sv =====
// Each neighbour transaction is inserted into the sorted cell row by the back end.
// An end marker inserts the diagonal, then the row drains one column per cycle while the
// output register is empty or being popped. Once the marker is taken, the back end first
// enters its drain state and then loads the first column into the output register. A
// four-entry command queue decouples the input from the back end. Reset clears the queue,
// row counters and output valid; the cell row needs no clearing.
module csr_row_builder_with_diagonal_sort import crb_pkg::*; #(
  parameter int unsigned ROW_CAPACITY = RowCapacity
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push,
  output logic              full,
  input  logic              op_i,
  input  logic [NodeW-1:0]  neighbour_node_i,
  output logic              empty,
  input  logic              pop,
  output logic [ColW-1:0]   column_o,
  output logic [StartW-1:0] row_start_o,
  output logic [NodeW-1:0]  row_number_o,
  output logic              last_in_row_o,
  output logic              row_overflow_o
);

  logic cmd_valid;
  logic cmd_ready;
  cmd_t cmd;

  crb_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .push_i           (push),
    .op_i             (op_i),
    .neighbour_node_i (neighbour_node_i),
    .full_o           (full),
    .cmd_valid_o      (cmd_valid),
    .cmd_o            (cmd),
    .cmd_ready_i      (cmd_ready)
  );

  crb_back #(
    .ROW_CAPACITY (ROW_CAPACITY)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_valid_i    (cmd_valid),
    .cmd_i          (cmd),
    .cmd_ready_o    (cmd_ready),
    .empty_o        (empty),
    .pop_i          (pop),
    .column_o       (column_o),
    .row_start_o    (row_start_o),
    .row_number_o   (row_number_o),
    .last_in_row_o  (last_in_row_o),
    .row_overflow_o (row_overflow_o)
  );

endmodule

// ===== tb/csr_row_builder_with_diagonal_sort_test.sv =====
`timescale 1ns / 1ps

module csr_row_builder_with_diagonal_sort_test;
  import crb_pkg::*;

  typedef struct packed {
    logic [ColW-1:0]   column;
    logic [StartW-1:0] row_start;
    logic [NodeW-1:0]  row_number;
    logic              last_in_row;
    logic              row_overflow;
  } nonzero_t;

  localparam int unsigned HoldCycles = 300;
  localparam int unsigned SettleCycles = 60;

  logic              clk_i;
  logic              rst_ni;
  logic              push;
  logic              full;
  logic              op_i;
  logic [NodeW-1:0]  neighbour_node_i;
  logic              empty;
  logic              pop;
  logic [ColW-1:0]   column_o;
  logic [StartW-1:0] row_start_o;
  logic [NodeW-1:0]  row_number_o;
  logic              last_in_row_o;
  logic              row_overflow_o;

  // Shadow copy of the row being built and of the running counters.
  logic [ColW-1:0]   row_cols [RowCapacity];
  int unsigned       row_fill;
  logic [NodeW-1:0]  node_now;
  logic [StartW-1:0] nnz_total;
  logic              dropped_seen;

  nonzero_t    expected_nonzeros[$];
  int unsigned mismatches;
  bit          idle_on;
  bit          hold_req;

  csr_row_builder_with_diagonal_sort DUT (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .push             (push),
    .full             (full),
    .op_i             (op_i),
    .neighbour_node_i (neighbour_node_i),
    .empty            (empty),
    .pop              (pop),
    .column_o         (column_o),
    .row_start_o      (row_start_o),
    .row_number_o     (row_number_o),
    .last_in_row_o    (last_in_row_o),
    .row_overflow_o   (row_overflow_o)
  );

  initial clk_i = 1'b0;
  always #6 clk_i = ~clk_i;

  initial begin
    #50ms;
    $display("DONE: errors detected");
    $finish;
  end

  // Updates the shadow row for one accepted transaction and queues the nonzeros it emits.
  task automatic build_row(input logic op, input logic [NodeW-1:0] nb);
    logic [ColW-1:0] sorted [RowCapacity];
    logic [ColW-1:0] key;
    nonzero_t        nz;
    int              j;
    if (op == OP_NEIGHBOUR) begin
      if (row_fill < RowCapacity) begin
        row_cols[row_fill] = ColW'(nb) + 1'b1;
        row_fill++;
      end else begin
        dropped_seen = 1'b1;
      end
    end else begin
      row_cols[0] = ColW'(node_now) + 1'b1;
      for (int i = 0; i < row_fill; i++) begin
        key = row_cols[i];
        j = i;
        while (j > 0 && sorted[j-1] > key) begin
          sorted[j] = sorted[j-1];
          j--;
        end
        sorted[j] = key;
      end
      for (int k = 0; k < row_fill; k++) begin
        nz.column = sorted[k];
        nz.row_start = nnz_total;
        nz.row_number = node_now;
        nz.last_in_row = (k == row_fill - 1);
        nz.row_overflow = dropped_seen;
        expected_nonzeros.push_back(nz);
      end
      nnz_total = nnz_total + StartW'(row_fill);
      node_now = (node_now == RowWrap) ? '0 : node_now + 1'b1;
      row_fill = 1;
      dropped_seen = 1'b0;
    end
  endtask

  // Offers one transaction, possibly after random idle cycles, and returns at the
  // rising edge where it is taken.
  task automatic send_item(input logic op, input logic [NodeW-1:0] nb);
    if (idle_on) begin
      while ($urandom_range(99) < 27) begin
        push <= 1'b0;
        @(posedge clk_i);
      end
    end
    push <= 1'b1;
    op_i <= op;
    neighbour_node_i <= nb;
    @(negedge clk_i);
    while (full) @(negedge clk_i);
    @(posedge clk_i);
    build_row(op, nb);
  endtask

  task automatic end_row();
    send_item(OP_END, NodeW'($urandom));
  endtask

  task automatic drain_all();
    push <= 1'b0;
    while (expected_nonzeros.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // Random columns in four picks of ten, the extremes in two and columns near the diagonal
  // in four, so that the sort has to place the diagonal among its neighbours.
  function automatic logic [NodeW-1:0] pick_neighbour();
    case ($urandom_range(9))
      0: return '0;
      1: return '1;
      2, 3, 4: return node_now + NodeW'($urandom_range(6)) - NodeW'(3);
      5: return node_now;
      default: return NodeW'($urandom);
    endcase
  endfunction

  task automatic send_random_row(input int unsigned length);
    for (int i = 0; i < length; i++) send_item(OP_NEIGHBOUR, pick_neighbour());
    end_row();
  endtask

  task automatic test_directed();
    // Row with no neighbours gives the diagonal alone.
    end_row();
    // Extremes, a self-loop and a duplicate.
    send_item(OP_NEIGHBOUR, 16'hFFFF);
    send_item(OP_NEIGHBOUR, 16'h0000);
    send_item(OP_NEIGHBOUR, 16'h0001);
    send_item(OP_NEIGHBOUR, 16'h0001);
    end_row();
    // Descending order forces every insertion after the first to shift.
    send_item(OP_NEIGHBOUR, 16'h0009);
    send_item(OP_NEIGHBOUR, 16'h0007);
    send_item(OP_NEIGHBOUR, 16'h0003);
    send_item(OP_NEIGHBOUR, 16'h0000);
    end_row();
    send_item(OP_NEIGHBOUR, 16'hAAAA);
    send_item(OP_NEIGHBOUR, 16'h5555);
    send_item(OP_NEIGHBOUR, 16'hFFFE);
    end_row();
    end_row();
    drain_all();
  endtask

  task automatic test_row_overflow();
    // Exactly full, then three neighbours too many.
    send_random_row(RowCapacity - 1);
    send_random_row(RowCapacity + 2);
    end_row();
    drain_all();
  endtask

  task automatic test_backpressure();
    hold_req = 1'b1;
    for (int r = 0; r < 2; r++) send_random_row(5 + r * 3);
    drain_all();
  endtask

  task automatic test_random();
    int unsigned sent;
    int unsigned pick;
    int unsigned length;
    sent = 0;
    while (sent < 70) begin
      // A stretch in the middle runs with no idling on either side.
      idle_on = !(sent >= 20 && sent < 50);
      pick = $urandom_range(99);
      if (pick < 10) length = 0;
      else if (pick < 70) length = $urandom_range(6, 1);
      else if (pick < 92) length = $urandom_range(20, 7);
      else length = $urandom_range(RowCapacity + 8, RowCapacity - 4);
      send_random_row(length);
      sent += length + 1;
    end
    idle_on = 1'b1;
    drain_all();
  endtask

  initial begin : receiver
    int unsigned hold_left;
    hold_left = 0;
    pop = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_left = HoldCycles;
        hold_req = 1'b0;
      end
      if (hold_left != 0) begin
        hold_left--;
        pop <= 1'b0;
      end else begin
        pop <= !idle_on || ($urandom_range(99) >= 27);
      end
    end
  end

  // The handshake signals are stable at the falling edge, so a transaction seen here
  // completes at the next rising edge.
  initial begin : checker_proc
    nonzero_t nz;
    forever begin
      @(negedge clk_i);
      if (rst_ni && pop && !empty) begin
        if (expected_nonzeros.size() == 0) begin
          mismatches++;
          $error("result with no transaction expected");
        end else begin
          nz = expected_nonzeros.pop_front();
          if (column_o !== nz.column) begin
            mismatches++;
            $error("column: expected %0d, actual %0d", nz.column, column_o);
          end
          if (row_start_o !== nz.row_start) begin
            mismatches++;
            $error("row_start: expected %0d, actual %0d", nz.row_start, row_start_o);
          end
          if (row_number_o !== nz.row_number) begin
            mismatches++;
            $error("row_number: expected %0d, actual %0d", nz.row_number, row_number_o);
          end
          if (last_in_row_o !== nz.last_in_row) begin
            mismatches++;
            $error("last_in_row: expected %0d, actual %0d", nz.last_in_row, last_in_row_o);
          end
          if (row_overflow_o !== nz.row_overflow) begin
            mismatches++;
            $error("row_overflow: expected %0d, actual %0d", nz.row_overflow,
                   row_overflow_o);
          end
        end
      end
    end
  end

  initial begin
    mismatches = 0;
    idle_on = 1'b1;
    hold_req = 1'b0;
    row_fill = 1;
    node_now = '0;
    nnz_total = '0;
    dropped_seen = 1'b0;
    push = 1'b0;
    op_i = OP_NEIGHBOUR;
    neighbour_node_i = '0;
    rst_ni = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_row_overflow();
    test_backpressure();
    test_random();

    if (mismatches == 0 && expected_nonzeros.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
